// ===== src/vas_pkg.sv =====
// Package: control word format, microprogram table and constants for the volume serial writer.
package vas_pkg;

  localparam int unsigned FrameBits = 11;
  localparam int unsigned StepW = 4;
  localparam int unsigned BitCntW = 4;

  localparam logic [10:0] FrameFixed = 11'h602;
  localparam logic [7:0] VolMax = 8'd28;
  localparam logic [6:0] AttBase = 7'd84;
  localparam logic [4:0] CoarseTop = 5'd21;
  localparam logic [1:0] FineTop = 2'd3;
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(FrameBits - 1);

  localparam logic [11:0] HoldLong = 12'd3000;
  localparam logic [11:0] HoldMid = 12'd2000;
  localparam logic [11:0] HoldShort = 12'd1500;

  typedef enum logic [1:0] {
    CLK_KEEP,
    CLK_LO,
    CLK_HI
  } clk_op_t;

  typedef enum logic [1:0] {
    DAT_KEEP,
    DAT_LO,
    DAT_HI,
    DAT_BIT
  } dat_op_t;

  typedef enum logic [1:0] {
    HOLD_L,
    HOLD_M,
    HOLD_S
  } hold_sel_t;

  typedef struct packed {
    clk_op_t          clk_op;
    dat_op_t          dat_op;
    hold_sel_t        hold_sel;
    logic             loop;     // shift the frame and jump back while bits remain
    logic [StepW-1:0] target;
    logic             last;
  } ctrl_word_t;

  // Step names of the microprogram.
  localparam logic [StepW-1:0] StIdle    = 4'd0;
  localparam logic [StepW-1:0] StStart   = 4'd1;
  localparam logic [StepW-1:0] StBitA    = 4'd2;
  localparam logic [StepW-1:0] StBitB    = 4'd3;
  localparam logic [StepW-1:0] StBitC    = 4'd4;
  localparam logic [StepW-1:0] StBitD    = 4'd5;
  localparam logic [StepW-1:0] StTrailA  = 4'd6;
  localparam logic [StepW-1:0] StTrailB  = 4'd7;
  localparam logic [StepW-1:0] StLatch   = 4'd8;

  function automatic ctrl_word_t ucode(input logic [StepW-1:0] step);
    ctrl_word_t cw;
    cw = '{clk_op: CLK_KEEP, dat_op: DAT_KEEP, hold_sel: HOLD_S,
           loop: 1'b0, target: StIdle, last: 1'b0};
    case (step)
      StIdle:   begin cw.clk_op = CLK_HI; cw.dat_op = DAT_HI; cw.hold_sel = HOLD_L; end
      StStart:  begin cw.clk_op = CLK_LO; cw.hold_sel = HOLD_M; end
      StBitA:   begin cw.dat_op = DAT_LO; end
      StBitB:   begin cw.clk_op = CLK_LO; end
      StBitC:   begin cw.dat_op = DAT_BIT; end
      StBitD:   begin cw.clk_op = CLK_HI; cw.loop = 1'b1; cw.target = StBitA; end
      StTrailA: begin cw.dat_op = DAT_HI; cw.hold_sel = HOLD_M; end
      StTrailB: begin cw.clk_op = CLK_LO; cw.hold_sel = HOLD_M; end
      StLatch:  begin cw.clk_op = CLK_HI; cw.hold_sel = HOLD_M; cw.last = 1'b1; end
      default:  begin cw.last = 1'b1; cw.hold_sel = HOLD_M; end
    endcase
    return cw;
  endfunction

endpackage

// ===== src/vas_if.sv =====
// Interfaces: request channel and pin phase channel with valid/ready handshake.
interface vas_req_if;
  logic       valid;
  logic       ready;
  logic       port;
  logic       channel;
  logic [7:0] volume;

  modport source (output valid, output port, output channel, output volume, input ready);
  modport sink (input valid, input port, input channel, input volume, output ready);
endinterface

interface vas_phase_if;
  logic        valid;
  logic        ready;
  logic        port_res;
  logic        clock_level;
  logic        data_level;
  logic [11:0] hold_time;
  logic        last;

  modport source (output valid, output port_res, output clock_level, output data_level,
                  output hold_time, output last, input ready);
  modport sink (input valid, input port_res, input clock_level, input data_level,
                input hold_time, input last, output ready);
endinterface

// ===== src/volume_attenuator_serial_write_core.sv =====
// Top level: microcoded serial volume writer for a two-port attenuator link.
//
// A request beat on req carries the pin pair (port), the chip channel and a
// volume level; volume above 28 is clamped. The block builds the 11-bit frame
// in the accept cycle and then runs a nine-step microprogram, one control
// word per step, that produces 49 pin phase beats on phase, the frame sent
// LSB first, with last set on the final latch phase.
// After a request is accepted, the step counter issues one phase per cycle
// while phase.ready is high or the output register holds no valid beat.
// req.ready is high only when no transfer is running; a new request is
// taken once the last phase has been loaded into the output register.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits on the same step. Synchronous reset clears the busy flag,
// the step counter and the output valid; no beat is lost or repeated.
module volume_attenuator_serial_write_core (
  input  logic       clk,
  input  logic       rst,
  vas_req_if.sink    req,
  vas_phase_if.source phase
);

  logic                         busy;
  logic [vas_pkg::StepW-1:0]    step;
  logic [vas_pkg::BitCntW-1:0]  bit_cnt;
  logic [10:0]                  frame;
  logic                         port_q;
  logic                         clk_q;
  logic                         dat_q;

  logic                         out_valid;
  logic                         out_clk;
  logic                         out_dat;
  logic [11:0]                  out_hold;
  logic                         out_last;
  logic                         out_port;

  vas_pkg::ctrl_word_t cw;
  logic        advance;
  logic        clk_next;
  logic        dat_next;
  logic [11:0] hold_next;
  logic [4:0]  vol_c;
  logic [6:0]  att;
  logic [10:0] frame_next;

  assign req.ready = !busy;
  assign advance   = busy && (!out_valid || phase.ready);
  assign cw        = vas_pkg::ucode(step);

  always_comb begin
    vol_c = (req.volume > vas_pkg::VolMax) ? vas_pkg::VolMax[4:0] : req.volume[4:0];
    att   = vas_pkg::AttBase - ({1'b0, vol_c, 1'b0} + {2'b00, vol_c});
    frame_next = vas_pkg::FrameFixed
               | {10'd0, req.channel}
               | {2'd0, 2'(vas_pkg::FineTop - att[1:0]), 7'd0}
               | {4'd0, 5'(vas_pkg::CoarseTop - att[6:2]), 2'd0};
  end

  always_comb begin
    unique case (cw.clk_op)
      vas_pkg::CLK_LO: clk_next = 1'b0;
      vas_pkg::CLK_HI: clk_next = 1'b1;
      default:         clk_next = clk_q;
    endcase
    unique case (cw.dat_op)
      vas_pkg::DAT_LO:  dat_next = 1'b0;
      vas_pkg::DAT_HI:  dat_next = 1'b1;
      vas_pkg::DAT_BIT: dat_next = frame[0];
      default:          dat_next = dat_q;
    endcase
    unique case (cw.hold_sel)
      vas_pkg::HOLD_L: hold_next = vas_pkg::HoldLong;
      vas_pkg::HOLD_M: hold_next = vas_pkg::HoldMid;
      default:         hold_next = vas_pkg::HoldShort;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= vas_pkg::StIdle;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        busy    <= 1'b1;
        step    <= vas_pkg::StIdle;
        bit_cnt <= '0;
        frame   <= frame_next;
        port_q  <= req.port;
        if (phase.ready) begin
          out_valid <= 1'b0;
        end
      end else if (advance) begin
        out_valid <= 1'b1;
        out_clk   <= clk_next;
        out_dat   <= dat_next;
        out_hold  <= hold_next;
        out_last  <= cw.last;
        out_port  <= port_q;
        clk_q     <= clk_next;
        dat_q     <= dat_next;
        if (cw.last) begin
          busy <= 1'b0;
        end else if (cw.loop) begin
          // Shift out the bit just sent; loop back until all frame bits are done.
          frame <= {1'b0, frame[10:1]};
          if (bit_cnt != vas_pkg::LastBit) begin
            bit_cnt <= bit_cnt + 1'b1;
            step    <= cw.target;
          end else begin
            step <= step + 1'b1;
          end
        end else begin
          step <= step + 1'b1;
        end
      end else if (phase.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign phase.valid       = out_valid;
  assign phase.port_res    = out_port;
  assign phase.clock_level = out_clk;
  assign phase.data_level  = out_dat;
  assign phase.hold_time   = out_hold;
  assign phase.last        = out_last;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (busy && step == vas_pkg::StIdle && bit_cnt == '0))
    else $error("accepted request did not start the microprogram");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && cw.last) |=> !busy)
    else $error("sequencer still busy after last phase was issued");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (bit_cnt <= vas_pkg::LastBit))
    else $error("frame bit counter out of range");

endmodule
